@@ hdl/weighted_content_id_sampler_defines.svh @@
// Assertion macros for the weighted content-id sampler.
`ifndef WEIGHTED_CONTENT_ID_SAMPLER_DEFINES_SVH
`define WEIGHTED_CONTENT_ID_SAMPLER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define WCIS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define WCIS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/wcis_pkg.sv @@
// Shared constants, codes and control types of the weighted content-id sampler.
`timescale 1ns / 1ps

package wcis_pkg;

	localparam int unsigned TABLE_ENTRIES = 65536;
	localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned CFG_W         = 31;
	localparam int unsigned STATUS_W      = 3;
	localparam int unsigned MODCNT_W      = $clog2(DATA_W);

	localparam logic [CNT_W-1:0]    FULL_COUNT  = CNT_W'(TABLE_ENTRIES);
	localparam logic [MODCNT_W-1:0] MOD_LAST    = MODCNT_W'(DATA_W - 1);
	localparam logic [CFG_W-1:0]    LIMIT_31    = 31'h7FFF_FFFF;
	localparam logic [CFG_W-1:0]    RANGE_RESET = 31'd29530586;
	localparam logic [DATA_W-1:0]   BASE_RESET  = 32'd10000000;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic CFG_DRAW_RANGE  = 1'b0;
	localparam logic CFG_UNIQUE_BASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_LOADED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUP    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNIQUE = 3'd4;

	typedef struct packed {
		logic capture;
		logic append;
		logic set_full;
		logic mod_step;
		logic eval;
		logic srch_read;
		logic srch_cmp;
		logic srch_finish;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic opcode;
		logic full;
		logic mod_last;
		logic search;
		logic srch_done;
	} stat_t;

endpackage

@@ hdl/wcis_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wcis_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/wcis_dpath.sv @@
// Datapath: config registers, prefix table, remainder units, binary search, result word.
`timescale 1ns / 1ps

module wcis_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wcis_pkg::cmd_t                cmd,
	output wcis_pkg::stat_t               st,
	input  logic                          opcode,
	input  logic [wcis_pkg::DATA_W-1:0]   occurrence_count,
	input  logic [wcis_pkg::DATA_W-1:0]   random_word,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [wcis_pkg::CFG_W-1:0]    cfg_data,
	output logic [wcis_pkg::STATUS_W-1:0] status,
	output logic [wcis_pkg::DATA_W-1:0]   content_id
);

	logic [wcis_pkg::CFG_W-1:0]    draw_range_q;
	logic [wcis_pkg::DATA_W-1:0]   unique_next_q;
	logic [wcis_pkg::CNT_W-1:0]    entry_count_q;
	logic [wcis_pkg::DATA_W-1:0]   running_total_q;

	logic [wcis_pkg::DATA_W-1:0]   word_q;
	logic [wcis_pkg::DATA_W-1:0]   wsh_q;
	logic [wcis_pkg::DATA_W-1:0]   lsh_q;
	logic [wcis_pkg::DATA_W-1:0]   count_q;
	logic [wcis_pkg::CFG_W-1:0]    range_q;
	logic [wcis_pkg::CFG_W-1:0]    rem_q;
	logic [wcis_pkg::CFG_W-1:0]    lim_q;
	logic [wcis_pkg::MODCNT_W-1:0] mod_cnt_q;
	logic [wcis_pkg::CNT_W-1:0]    lo_q;
	logic [wcis_pkg::CNT_W-1:0]    hi_q;
	logic [wcis_pkg::CNT_W-1:0]    mid_q;
	logic [wcis_pkg::STATUS_W-1:0] res_status_q;
	logic [wcis_pkg::DATA_W-1:0]   res_id_q;
	logic [wcis_pkg::STATUS_W-1:0] status_q;
	logic [wcis_pkg::DATA_W-1:0]   content_id_q;

	logic [wcis_pkg::DATA_W-1:0]   range_ext;
	logic [wcis_pkg::DATA_W-1:0]   rem_sh;
	logic [wcis_pkg::DATA_W-1:0]   lim_sh;
	logic [wcis_pkg::DATA_W-1:0]   rem_nx;
	logic [wcis_pkg::DATA_W-1:0]   lim_nx;
	logic [wcis_pkg::DATA_W-1:0]   threshold;
	logic [wcis_pkg::DATA_W-1:0]   rem_ext;
	logic                          reject;
	logic                          is_unique;
	logic [wcis_pkg::DATA_W-1:0]   total_nx;
	logic [wcis_pkg::CNT_W-1:0]    mid;
	logic [wcis_pkg::DATA_W-1:0]   rdata;

	// one restoring step of word mod range and limit mod range
	assign range_ext = {1'b0, range_q};
	assign rem_sh    = {rem_q, wsh_q[wcis_pkg::DATA_W-1]};
	assign lim_sh    = {lim_q, lsh_q[wcis_pkg::DATA_W-1]};
	assign rem_nx    = (rem_sh >= range_ext) ? rem_sh - range_ext : rem_sh;
	assign lim_nx    = (lim_sh >= range_ext) ? lim_sh - range_ext : lim_sh;

	assign threshold = {1'b0, wcis_pkg::LIMIT_31} - {1'b0, lim_q};
	assign rem_ext   = {1'b0, rem_q};
	assign reject    = word_q >= threshold;
	assign is_unique = rem_ext >= running_total_q;
	assign total_nx  = running_total_q + count_q;
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);

	assign st.opcode    = opcode;
	assign st.full      = entry_count_q == wcis_pkg::FULL_COUNT;
	assign st.mod_last  = mod_cnt_q == wcis_pkg::MOD_LAST;
	assign st.search    = !reject && !is_unique;
	assign st.srch_done = !(lo_q < hi_q);

	wcis_ram #(
		.WIDTH (wcis_pkg::DATA_W),
		.DEPTH (wcis_pkg::TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (entry_count_q[wcis_pkg::IDX_W-1:0]),
		.wdata (total_nx),
		.re    (cmd.srch_read),
		.raddr (mid[wcis_pkg::IDX_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_range_q    <= wcis_pkg::RANGE_RESET;
			unique_next_q   <= wcis_pkg::BASE_RESET;
			entry_count_q   <= '0;
			running_total_q <= '0;
			mod_cnt_q       <= '0;
		end else begin
			if (cfg_we && cfg_index == wcis_pkg::CFG_DRAW_RANGE) begin
				draw_range_q <= cfg_data;
			end
			if (cfg_we && cfg_index == wcis_pkg::CFG_UNIQUE_BASE) begin
				unique_next_q <= {1'b0, cfg_data};
			end else if (cmd.eval && !reject && is_unique) begin
				unique_next_q <= unique_next_q + 32'd1;
			end
			if (cmd.append) begin
				running_total_q <= total_nx;
				entry_count_q   <= entry_count_q + 1'b1;
			end
			if (cmd.capture) begin
				mod_cnt_q <= '0;
			end else if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			word_q  <= random_word;
			wsh_q   <= random_word;
			lsh_q   <= {1'b0, wcis_pkg::LIMIT_31};
			count_q <= occurrence_count;
			range_q <= (draw_range_q == '0) ? wcis_pkg::CFG_W'(1) : draw_range_q;
			rem_q   <= '0;
			lim_q   <= '0;
		end
		if (cmd.mod_step) begin
			wsh_q <= wsh_q << 1;
			lsh_q <= lsh_q << 1;
			rem_q <= rem_nx[wcis_pkg::CFG_W-1:0];
			lim_q <= lim_nx[wcis_pkg::CFG_W-1:0];
		end
		if (cmd.append) begin
			res_status_q <= wcis_pkg::ST_LOADED;
			res_id_q     <= '0;
		end
		if (cmd.set_full) begin
			res_status_q <= wcis_pkg::ST_FULL;
			res_id_q     <= '0;
		end
		if (cmd.eval) begin
			lo_q <= '0;
			hi_q <= entry_count_q;
			// a search result is written when the search finishes
			if (reject) begin
				res_status_q <= wcis_pkg::ST_REJECT;
				res_id_q     <= '0;
			end else if (is_unique) begin
				res_status_q <= wcis_pkg::ST_UNIQUE;
				res_id_q     <= unique_next_q;
			end
		end
		if (cmd.srch_read) begin
			mid_q <= mid;
		end
		if (cmd.srch_cmp) begin
			if (rdata > rem_ext) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_q + 1'b1;
			end
		end
		if (cmd.srch_finish) begin
			res_status_q <= wcis_pkg::ST_DUP;
			res_id_q     <= wcis_pkg::DATA_W'(lo_q);
		end
		if (cmd.out_load) begin
			status_q     <= res_status_q;
			content_id_q <= res_id_q;
		end
	end

	assign status     = status_q;
	assign content_id = content_id_q;

endmodule

@@ hdl/wcis_ctrl.sv @@
// Controller: sequences load, modulo, evaluation, search and result hand-off.
`timescale 1ns / 1ps

module wcis_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  wcis_pkg::stat_t st,
	output wcis_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_MOD,
		S_EVAL,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
			end
			S_LOAD: begin
				cmd.set_full = st.full;
				cmd.append   = !st.full;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
			end
			S_SRCH_RD: begin
				cmd.srch_finish = st.srch_done;
				cmd.srch_read   = !st.srch_done;
			end
			S_SRCH_CMP: begin
				cmd.srch_cmp = 1'b1;
			end
			S_FIN: begin
				cmd.out_load = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (st.opcode == wcis_pkg::OP_SAMPLE) ? S_MOD : S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_FIN;
				end
				S_MOD: begin
					if (st.mod_last) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= st.search ? S_SRCH_RD : S_FIN;
				end
				S_SRCH_RD: begin
					state_q <= st.srch_done ? S_FIN : S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					state_q <= S_SRCH_RD;
				end
				S_FIN: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/weighted_content_id_sampler.sv @@
// Weighted content-id sampler, top level.
//
// Input channel (in_valid/in_ready) takes one word per item: opcode 0 appends
// occurrence_count to the prefix-sum table, opcode 1 draws with random_word.
// Output channel (out_valid/out_ready) returns one word per item: status and
// content_id. Config channel (cfg_valid/cfg_ready, always ready) writes
// draw_range (index 0) or unique_base (index 1, also reloads the unique counter).
// One item is worked on at a time; in_ready is high only when the controller idles.
// Draw: the 32-step bit-serial remainder unit runs first; when a table index
// is returned, a binary search of up to 17 reads (for 65536 entries) follows.
// Each search probe reads the table RAM's registered read port, then compares.
// A finished word sits in the output register; the next item is accepted
// while it waits, and that item stalls in its last cycle until the register frees.
// Reset clears the table count, running total and output valid, restores
// draw_range and unique_base defaults; table contents are not cleared.
`timescale 1ns / 1ps
`include "weighted_content_id_sampler_defines.svh"

module weighted_content_id_sampler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [wcis_pkg::DATA_W-1:0]   occurrence_count,
	input  logic [wcis_pkg::DATA_W-1:0]   random_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wcis_pkg::STATUS_W-1:0] status,
	output logic [wcis_pkg::DATA_W-1:0]   content_id,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [wcis_pkg::CFG_W-1:0]    cfg_data
);

	wcis_pkg::cmd_t  cmd;
	wcis_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	wcis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	wcis_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.opcode           (opcode),
		.occurrence_count (occurrence_count),
		.random_word      (random_word),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.status           (status),
		.content_id       (content_id)
	);

	`WCIS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	`WCIS_ASSERT_NXT(a_load_shows_valid, cmd.out_load, out_valid, "loaded word not valid")
	`WCIS_ASSERT_IMP(a_valid_from_load, $rose(out_valid), $past(cmd.out_load), "valid without load")

endmodule

@@ tb/tb_weighted_content_id_sampler.sv @@
// Testbench for the weighted content-id sampler: directed and random words checked by a predictor.
`timescale 1ns / 1ps

module tb_weighted_content_id_sampler;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 10;
	localparam int TAIL_CYCLES = 100;
	// ~2k words, with margin
	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic [wcis_pkg::STATUS_W-1:0] st;
		logic [wcis_pkg::DATA_W-1:0]   id;
	} outcome_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          opcode = wcis_pkg::OP_LOAD;
	logic [wcis_pkg::DATA_W-1:0]   occurrence_count = '0;
	logic [wcis_pkg::DATA_W-1:0]   random_word = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [wcis_pkg::STATUS_W-1:0] status;
	logic [wcis_pkg::DATA_W-1:0]   content_id;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic                          cfg_index = wcis_pkg::CFG_DRAW_RANGE;
	logic [wcis_pkg::CFG_W-1:0]    cfg_data = '0;

	// predictor state
	logic [wcis_pkg::DATA_W-1:0] prefix_sums [wcis_pkg::TABLE_ENTRIES];
	int unsigned                 loaded_entries = 0;
	logic [wcis_pkg::DATA_W-1:0] total_occ = '0;
	logic [wcis_pkg::DATA_W-1:0] next_unique = wcis_pkg::BASE_RESET;
	logic [wcis_pkg::CFG_W-1:0]  range_reg = wcis_pkg::RANGE_RESET;

	outcome_t    outcomes_due [$];
	int unsigned errors = 0;
	int unsigned burst_left = 0;
	bit          tx_raised = 1'b0;
	int unsigned rx_phase_left = 0;
	int unsigned rx_stall_left = 0;
	bit          rx_calm = 1'b0;

	weighted_content_id_sampler u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.occurrence_count (occurrence_count),
		.random_word      (random_word),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.content_id       (content_id),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic logic [wcis_pkg::DATA_W-1:0] draw_span();
		return (range_reg == '0) ? 32'd1 : {1'b0, range_reg};
	endfunction

	function automatic logic [wcis_pkg::DATA_W-1:0] draw_cut();
		logic [wcis_pkg::DATA_W-1:0] span;
		span = draw_span();
		return ({1'b0, wcis_pkg::LIMIT_31} / span) * span;
	endfunction

	function automatic outcome_t predict_outcome(input logic op,
			input logic [wcis_pkg::DATA_W-1:0] count,
			input logic [wcis_pkg::DATA_W-1:0] word);
		outcome_t                    res;
		logic [wcis_pkg::DATA_W-1:0] r;
		int unsigned                 lo, hi, mid;
		res.st = wcis_pkg::ST_LOADED;
		res.id = '0;
		if (op == wcis_pkg::OP_LOAD) begin
			if (loaded_entries < wcis_pkg::TABLE_ENTRIES) begin
				total_occ = total_occ + count;
				prefix_sums[loaded_entries] = total_occ;
				loaded_entries++;
			end else
				res.st = wcis_pkg::ST_FULL;
		end else if (word >= draw_cut()) begin
			res.st = wcis_pkg::ST_REJECT;
		end else begin
			r = word % draw_span();
			if (r >= total_occ) begin
				res.st = wcis_pkg::ST_UNIQUE;
				res.id = next_unique;
				next_unique = next_unique + 1;
			end else begin
				lo = 0;
				hi = loaded_entries;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (prefix_sums[mid] > r)
						hi = mid;
					else
						lo = mid + 1;
				end
				res.st = wcis_pkg::ST_DUP;
				res.id = lo;
			end
		end
		return res;
	endfunction

	// range about twice the table total, so draws split between hits and unique ids
	function automatic logic [wcis_pkg::CFG_W-1:0] balanced_range();
		if (total_occ >= 32'h4000_0000)
			return wcis_pkg::LIMIT_31;
		return wcis_pkg::CFG_W'(2 * total_occ + $urandom_range(1, 64));
	endfunction

	function automatic logic [wcis_pkg::DATA_W-1:0] pick_count();
		case ($urandom_range(0, 99))
			0: return $urandom();
			1, 2, 3: return $urandom_range(0, 1 << 20);
			default: return $urandom_range(0, 16);
		endcase
	endfunction

	function automatic logic [wcis_pkg::DATA_W-1:0] pick_word();
		logic [wcis_pkg::DATA_W-1:0] cut;
		logic [wcis_pkg::DATA_W-1:0] w;
		cut = draw_cut();
		case ($urandom_range(0, 11))
			0: w = $urandom();
			1: w = cut - 1 + $urandom_range(0, 3);
			2: w = total_occ - $urandom_range(0, 1);
			3: w = (loaded_entries == 0) ? '0 :
				prefix_sums[$urandom_range(0, loaded_entries - 1)] - $urandom_range(0, 1);
			default: w = $urandom_range(0, cut - 1);
		endcase
		return w;
	endfunction

	task automatic send_word(input logic op, input logic [wcis_pkg::DATA_W-1:0] count,
			input logic [wcis_pkg::DATA_W-1:0] word);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				if (tx_raised) begin
					in_valid <= 1'b0;
					tx_raised = 1'b0;
				end
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		tx_raised = 1'b1;
		opcode <= op;
		occurrence_count <= count;
		random_word <= word;
		do @(posedge clk); while (!in_ready);
		outcomes_due.push_back(predict_outcome(op, count, word));
	endtask

	task automatic wait_results();
		if (tx_raised) begin
			in_valid <= 1'b0;
			tx_raised = 1'b0;
		end
		burst_left = 0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [wcis_pkg::CFG_W-1:0] value,
			input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (last)
			cfg_valid <= 1'b0;
		if (idx == wcis_pkg::CFG_DRAW_RANGE)
			range_reg = value;
		else
			next_unique = {1'b0, value};
	endtask

	task automatic test_empty_table_draws();
		send_word(wcis_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 32'h0);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'hFFFF_FFFF);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, draw_cut() - 1);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, draw_cut());
	endtask

	task automatic test_register_extremes();
		wait_results();
		// zero range acts as one
		write_reg(wcis_pkg::CFG_DRAW_RANGE, '0, 1'b0);
		write_reg(wcis_pkg::CFG_UNIQUE_BASE, wcis_pkg::LIMIT_31, 1'b1);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'h0);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'h7FFF_FFFE);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'h7FFF_FFFF);
		wait_results();
		write_reg(wcis_pkg::CFG_DRAW_RANGE, wcis_pkg::CFG_W'(1), 1'b0);
		write_reg(wcis_pkg::CFG_UNIQUE_BASE, '0, 1'b1);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'd12345);
		wait_results();
		write_reg(wcis_pkg::CFG_DRAW_RANGE, wcis_pkg::LIMIT_31, 1'b1);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'h7FFF_FFFE);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'h7FFF_FFFF);
	endtask

	task automatic test_load_and_search();
		wait_results();
		write_reg(wcis_pkg::CFG_DRAW_RANGE, wcis_pkg::CFG_W'(16), 1'b1);
		// prefix sums 0, 3, 3, 8: zero counts give repeated sums
		send_word(wcis_pkg::OP_LOAD, 32'd0, 32'hFFFF_FFFF);
		send_word(wcis_pkg::OP_LOAD, 32'd3, 32'hFFFF_FFFF);
		send_word(wcis_pkg::OP_LOAD, 32'd0, 32'hFFFF_FFFF);
		send_word(wcis_pkg::OP_LOAD, 32'd5, 32'hFFFF_FFFF);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'd0);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'd2);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'd3);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'd7);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'd8);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, 32'd19);
		send_word(wcis_pkg::OP_SAMPLE, 32'h0, draw_cut() - 1);
	endtask

	task automatic test_random_mix();
		logic [wcis_pkg::CFG_W-1:0] range_pick;
		for (int pass_no = 0; pass_no < 8; pass_no++) begin
			wait_results();
			case (pass_no % 4)
				1: range_pick = wcis_pkg::CFG_W'($urandom_range(1, 64));
				2: range_pick = wcis_pkg::LIMIT_31;
				3: range_pick = wcis_pkg::CFG_W'($urandom_range(1, 32'h7FFF_FFFF));
				default: range_pick = balanced_range();
			endcase
			if (pass_no % 3 == 2) begin
				write_reg(wcis_pkg::CFG_DRAW_RANGE, range_pick, 1'b0);
				write_reg(wcis_pkg::CFG_UNIQUE_BASE, wcis_pkg::CFG_W'($urandom()), 1'b1);
			end else
				write_reg(wcis_pkg::CFG_DRAW_RANGE, range_pick, 1'b1);
			repeat (240) begin
				if ($urandom_range(0, 9) < 3)
					send_word(wcis_pkg::OP_LOAD, pick_count(), $urandom());
				else
					send_word(wcis_pkg::OP_SAMPLE, $urandom(), pick_word());
			end
		end
	endtask

	task automatic test_total_wrap();
		wait_results();
		// wrap the running total so it restarts at five
		send_word(wcis_pkg::OP_LOAD, ~total_occ + 32'd6, 32'hFFFF_FFFF);
		repeat (20) send_word(wcis_pkg::OP_LOAD, $urandom_range(0, 3), $urandom());
		wait_results();
		write_reg(wcis_pkg::CFG_DRAW_RANGE, balanced_range(), 1'b1);
		repeat (60) send_word(wcis_pkg::OP_SAMPLE, $urandom(), pick_word());
	endtask

	// receiver: calm stretches and choppy stretches with short stalls
	always @(posedge clk) begin
		if (rx_phase_left == 0) begin
			rx_phase_left = $urandom_range(20, 400);
			rx_calm = ($urandom_range(0, 2) == 0);
		end else
			rx_phase_left--;
		if (rx_stall_left != 0) begin
			rx_stall_left--;
			out_ready <= 1'b0;
		end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
			rx_stall_left = $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (outcomes_due.size() == 0) begin
				$display("%0t: unexpected word, status %0d content_id %0d",
					$time, status, content_id);
				errors++;
			end else begin
				want = outcomes_due.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d, got %0d", $time, want.st, status);
					errors++;
				end
				if (content_id !== want.id) begin
					$display("%0t: content_id expected %0d, got %0d",
						$time, want.id, content_id);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table_draws();
		test_register_extremes();
		test_load_and_search();
		test_random_mix();
		test_total_wrap();
		wait_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
